### rtl/sosrt_pkg.sv
`timescale 1ns / 1ps
package sosrt_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int VALUE_BITS_DEF    = 16;

    localparam logic [3:0] PH_START  = 4'd0;
    localparam logic [3:0] PH_X_SIGN = 4'd1;
    localparam logic [3:0] PH_X_DIG  = 4'd2;
    localparam logic [3:0] PH_Y_WS   = 4'd3;
    localparam logic [3:0] PH_Y_SIGN = 4'd4;
    localparam logic [3:0] PH_Y_DIG  = 4'd5;
    localparam logic [3:0] PH_DONE   = 4'd6;
    localparam logic [3:0] PH_BAD    = 4'd7;

    localparam logic [2:0] REG_STOP_BAND = 3'd0;
    localparam logic [2:0] REG_GAIN      = 3'd1;
    localparam logic [2:0] REG_MIN_RATE  = 3'd2;
    localparam logic [2:0] REG_MAX_RATE  = 3'd3;
    localparam logic [2:0] REG_TIMER_CLK = 3'd4;
    localparam logic [2:0] REG_TIMEOUT   = 3'd5;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef struct packed {
        logic [15:0] stop_band;
        logic [7:0]  step_gain;
        logic [15:0] min_step_rate;
        logic [15:0] max_step_rate;
        logic [23:0] timer_clock;
        logic [15:0] line_timeout;
    } cfg_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

### rtl/sosrt_divider.sv
`timescale 1ns / 1ps
module sosrt_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [23:0] divisor,
    output logic        busy,
    output logic [23:0] quotient
);

    logic [23:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [24:0] trial;

    assign trial = {rem_reg[23:0], quo_reg[23]} - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[24])
            begin
                rem_next = trial;
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[23:0], quo_reg[23]};
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/sosrt_parser.sv
`timescale 1ns / 1ps
module sosrt_parser
#(
    parameter int LINE_CAPACITY = sosrt_pkg::LINE_CAPACITY_DEF,
    parameter int VALUE_BITS    = sosrt_pkg::VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_en,
    input  logic                  restart,
    input  logic [7:0]            c,
    output logic                  line_ok,
    output logic                  x_neg,
    output logic [VALUE_BITS-1:0] x_mag,
    output logic                  y_neg,
    output logic [VALUE_BITS-1:0] y_mag
);

    localparam int CW = $clog2(LINE_CAPACITY);

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [3:0]            ph_reg, ph_next;
    logic                  xn_reg, xn_next, yn_reg, yn_next;
    logic [VALUE_BITS-1:0] xm_reg, xm_next, ym_reg, ym_next;
    logic [VALUE_BITS-1:0] acc_in, acc_out;
    logic [VALUE_BITS+3:0] acc_wide;
    logic                  dig, blank, sgn;

    assign dig   = sosrt_pkg::is_digit(c);
    assign blank = sosrt_pkg::is_blank(c);
    assign sgn   = (c == sosrt_pkg::CH_MINUS) || (c == sosrt_pkg::CH_PLUS);

    assign acc_in   = (ph_reg == sosrt_pkg::PH_X_DIG) ? xm_reg :
                      (ph_reg == sosrt_pkg::PH_Y_DIG) ? ym_reg : '0;
    assign acc_wide = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0}
                      + (VALUE_BITS+4)'(c[3:0]);
    assign acc_out  = (acc_wide > (VALUE_BITS+4)'({VALUE_BITS{1'b1}})) ?
                      {VALUE_BITS{1'b1}} : acc_wide[VALUE_BITS-1:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        ph_next  = ph_reg;
        xn_next  = xn_reg;
        yn_next  = yn_reg;
        xm_next  = xm_reg;
        ym_next  = ym_reg;
        if (restart || (char_en && cnt_reg == CW'(LINE_CAPACITY - 1)))
        begin
            cnt_next = '0;
            ph_next  = sosrt_pkg::PH_START;
            xn_next  = 1'b0;
            yn_next  = 1'b0;
            xm_next  = '0;
            ym_next  = '0;
        end
        else if (char_en)
        begin
            cnt_next = cnt_reg + CW'(1);
            case (ph_reg)
                sosrt_pkg::PH_START:
                begin
                    if (blank) ph_next = ph_reg;
                    else if (sgn)
                    begin
                        xn_next = (c == sosrt_pkg::CH_MINUS);
                        ph_next = sosrt_pkg::PH_X_SIGN;
                    end
                    else if (dig)
                    begin
                        xm_next = acc_out;
                        ph_next = sosrt_pkg::PH_X_DIG;
                    end
                    else ph_next = sosrt_pkg::PH_BAD;
                end
                sosrt_pkg::PH_X_SIGN:
                begin
                    if (dig)
                    begin
                        xm_next = acc_out;
                        ph_next = sosrt_pkg::PH_X_DIG;
                    end
                    else ph_next = sosrt_pkg::PH_BAD;
                end
                sosrt_pkg::PH_X_DIG:
                begin
                    if (dig) xm_next = acc_out;
                    else if (c == sosrt_pkg::CH_COMMA) ph_next = sosrt_pkg::PH_Y_WS;
                    else ph_next = sosrt_pkg::PH_BAD;
                end
                sosrt_pkg::PH_Y_WS:
                begin
                    if (blank) ph_next = ph_reg;
                    else if (sgn)
                    begin
                        yn_next = (c == sosrt_pkg::CH_MINUS);
                        ph_next = sosrt_pkg::PH_Y_SIGN;
                    end
                    else if (dig)
                    begin
                        ym_next = acc_out;
                        ph_next = sosrt_pkg::PH_Y_DIG;
                    end
                    else ph_next = sosrt_pkg::PH_BAD;
                end
                sosrt_pkg::PH_Y_SIGN:
                begin
                    if (dig)
                    begin
                        ym_next = acc_out;
                        ph_next = sosrt_pkg::PH_Y_DIG;
                    end
                    else ph_next = sosrt_pkg::PH_BAD;
                end
                sosrt_pkg::PH_Y_DIG:
                begin
                    if (dig) ym_next = acc_out;
                    else ph_next = sosrt_pkg::PH_DONE;
                end
                sosrt_pkg::PH_DONE: ph_next = ph_reg;
                default: ph_next = sosrt_pkg::PH_BAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ph_reg  <= sosrt_pkg::PH_START;
            xn_reg  <= 1'b0;
            yn_reg  <= 1'b0;
            xm_reg  <= '0;
            ym_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ph_reg  <= ph_next;
            xn_reg  <= xn_next;
            yn_reg  <= yn_next;
            xm_reg  <= xm_next;
            ym_reg  <= ym_next;
        end
    end

    assign line_ok = (ph_reg == sosrt_pkg::PH_Y_DIG) || (ph_reg == sosrt_pkg::PH_DONE);
    assign x_neg   = xn_reg;
    assign x_mag   = xm_reg;
    assign y_neg   = yn_reg;
    assign y_mag   = ym_reg;

endmodule

### rtl/serial_offset_stepper_rate_tracker.sv
// Ticks, CR, ordinary bytes and bad-line newlines go from S_AXIS straight to S_OUT with their result.
// A good-line newline also passes S_MUL, S_DIV and S_WAIT for each moving axis, using
// the shared 24-step divider for one axis after the other, then reaches S_OUT.
// Items are taken one at a time, at the earliest in the cycle after the previous result transfer.
// Reset: rst_n, asynchronous, active low; registers return to their default values,
// the line restarts empty, the target is lost and both axes are stopped.
`timescale 1ns / 1ps
module serial_offset_stepper_rate_tracker
#(
    parameter int LINE_CAPACITY = sosrt_pkg::LINE_CAPACITY_DEF,
    parameter int VALUE_BITS    = sosrt_pkg::VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tgt_locked,
    output logic        line_done,
    output logic        pan_run,
    output logic        pan_dir,
    output logic [23:0] pan_reload,
    output logic [23:0] pan_compare,
    output logic        tilt_run,
    output logic        tilt_dir,
    output logic [23:0] tilt_reload,
    output logic [23:0] tilt_compare
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AXIS = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    sosrt_pkg::cfg_t cfg_reg;

    logic [2:0]  st_reg;
    logic        kind_reg;
    logic [7:0]  c_reg;
    logic        ax_reg;
    logic        found_reg, done_reg;
    logic [15:0] ms_reg;
    logic [1:0]  run_reg, dir_reg;
    logic [23:0] rl_reg [2];
    logic [VALUE_BITS+7:0] freq_reg;

    logic                  line_ok, xn, yn;
    logic [VALUE_BITS-1:0] xm, ym;
    logic                  char_en, accept;
    logic                  line_end_restart;
    logic                  div_start, div_busy;
    logic [23:0]           quo;
    logic [23:0]           div_den;
    logic [VALUE_BITS+7:0] freq_c;
    logic                  ax_neg;
    logic [VALUE_BITS-1:0] ax_mag;
    logic [15:0]           ms_inc;

    assign accept  = in_valid && !in_stall;
    assign in_stall = (st_reg != S_IDLE);
    assign char_en = (st_reg == S_AXIS) && !kind_reg && c_reg != sosrt_pkg::CH_LF
                     && c_reg != sosrt_pkg::CH_CR && ax_reg == 1'b0;
    assign line_end_restart = (st_reg == S_OUT) && !kind_reg && c_reg == sosrt_pkg::CH_LF
                              && !out_stall;

    sosrt_parser #(.LINE_CAPACITY(LINE_CAPACITY), .VALUE_BITS(VALUE_BITS)) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_en (char_en),
        .restart (line_end_restart),
        .c       (c_reg),
        .line_ok (line_ok),
        .x_neg   (xn),
        .x_mag   (xm),
        .y_neg   (yn),
        .y_mag   (ym)
    );

    assign ax_neg = ax_reg ? yn : xn;
    assign ax_mag = ax_reg ? ym : xm;

    always_comb
    begin
        freq_c = freq_reg;
        if (freq_c < (VALUE_BITS+8)'(cfg_reg.min_step_rate))
            freq_c = (VALUE_BITS+8)'(cfg_reg.min_step_rate);
        if (freq_c > (VALUE_BITS+8)'(cfg_reg.max_step_rate))
            freq_c = (VALUE_BITS+8)'(cfg_reg.max_step_rate);
        if (freq_c == '0) freq_c = (VALUE_BITS+8)'(1);
    end

    assign div_den   = 24'(freq_c);
    assign div_start = (st_reg == S_DIV);

    sosrt_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg_reg.timer_clock),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign ms_inc = (ms_reg == 16'hFFFF) ? ms_reg : ms_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_band     <= 16'd10;
            cfg_reg.step_gain     <= 8'd6;
            cfg_reg.min_step_rate <= 16'd150;
            cfg_reg.max_step_rate <= 16'd1500;
            cfg_reg.timer_clock   <= 24'd1000000;
            cfg_reg.line_timeout  <= 16'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sosrt_pkg::REG_STOP_BAND: cfg_reg.stop_band     <= cfg_data[15:0];
                sosrt_pkg::REG_GAIN:      cfg_reg.step_gain     <= cfg_data[7:0];
                sosrt_pkg::REG_MIN_RATE:  cfg_reg.min_step_rate <= cfg_data[15:0];
                sosrt_pkg::REG_MAX_RATE:  cfg_reg.max_step_rate <= cfg_data[15:0];
                sosrt_pkg::REG_TIMER_CLK: cfg_reg.timer_clock   <= cfg_data[23:0];
                sosrt_pkg::REG_TIMEOUT:   cfg_reg.line_timeout  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            kind_reg  <= 1'b0;
            c_reg     <= '0;
            ax_reg    <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
            ms_reg    <= '0;
            run_reg   <= '0;
            dir_reg   <= '0;
            rl_reg[0] <= '0;
            rl_reg[1] <= '0;
            freq_reg  <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg <= kind;
                        c_reg    <= data_byte;
                        ax_reg   <= 1'b0;
                        done_reg <= 1'b0;
                        st_reg   <= S_AXIS;
                    end
                end
                S_AXIS:
                begin
                    if (kind_reg)
                    begin
                        ms_reg <= ms_inc;
                        if (found_reg && ms_inc > cfg_reg.line_timeout)
                        begin
                            found_reg <= 1'b0;
                            run_reg   <= 2'b00;
                        end
                        st_reg <= S_OUT;
                    end
                    else if (c_reg == sosrt_pkg::CH_LF)
                    begin
                        done_reg <= 1'b1;
                        ms_reg   <= '0;
                        if (!line_ok)
                        begin
                            found_reg <= 1'b0;
                            run_reg   <= 2'b00;
                            st_reg    <= S_OUT;
                        end
                        else
                        begin
                            found_reg <= 1'b1;
                            if (32'(ax_mag) <= 32'(cfg_reg.stop_band))
                            begin
                                run_reg[ax_reg] <= 1'b0;
                                if (ax_reg) st_reg <= S_OUT;
                                else ax_reg <= 1'b1;
                            end
                            else
                            begin
                                dir_reg[ax_reg] <= !ax_neg;
                                st_reg          <= S_MUL;
                            end
                        end
                    end
                    else
                        st_reg <= S_OUT;
                end
                S_MUL:
                begin
                    freq_reg <= (VALUE_BITS+8)'(ax_mag) * (VALUE_BITS+8)'(cfg_reg.step_gain);
                    st_reg   <= S_DIV;
                end
                S_DIV:
                    st_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!div_busy)
                    begin
                        rl_reg[ax_reg]  <= (quo == 24'd0) ? 24'd0 : quo - 24'd1;
                        run_reg[ax_reg] <= 1'b1;
                        if (ax_reg) st_reg <= S_OUT;
                        else
                        begin
                            ax_reg <= 1'b1;
                            st_reg <= S_AXIS;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        ax_reg <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = (st_reg == S_OUT);
    assign tgt_locked   = found_reg;
    assign line_done    = done_reg;
    assign pan_run      = run_reg[0];
    assign pan_dir      = dir_reg[0];
    assign pan_reload   = rl_reg[0];
    assign pan_compare  = 24'(({1'b0, rl_reg[0]} + 25'd1) >> 1);
    assign tilt_run     = run_reg[1];
    assign tilt_dir     = dir_reg[1];
    assign tilt_reload  = rl_reg[1];
    assign tilt_compare = 24'(({1'b0, rl_reg[1]} + 25'd1) >> 1);

endmodule
